// File: rtl/core/cisf_pkg.sv
// shared types, constants and the case-fold helper for the substring search core
// no dependencies

package cisf_pkg;

    localparam int unsigned CFG_ADDR_W  = 6;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned LEN_W       = 7;
    localparam int unsigned CFG_LEN_W   = 6;
    localparam int unsigned PAT_WORDS   = 4;
    localparam int unsigned PAT_BYTES   = 32;
    localparam int unsigned BYTE_W      = 8;

    localparam logic [LEN_W-1:0] NO_MATCH_LEN = 7'h7F;

    typedef enum logic [2:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD_0 = 3'd1,
        REG_PATTERN_WORD_1 = 3'd2,
        REG_PATTERN_WORD_2 = 3'd3,
        REG_PATTERN_WORD_3 = 3'd4
    } cisf_reg_t;

    typedef struct packed {
        logic [CFG_LEN_W-1:0]                  pattern_length;
        logic [PAT_WORDS-1:0][CFG_DATA_W-1:0]  pattern_word;
    } cisf_cfg_t;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/cisf_regs.sv
// apb register file holding the pattern length and the four pattern words
// depends on cisf_pkg

module cisf_regs
    import cisf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cisf_cfg_t             cfg
);

    cisf_cfg_t cfg_reg;
    logic      wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_ADDR_W-1:3];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PATTERN_LENGTH: cfg_reg.pattern_length  <= pwdata[CFG_LEN_W-1:0];
                REG_PATTERN_WORD_0: cfg_reg.pattern_word[0] <= pwdata;
                REG_PATTERN_WORD_1: cfg_reg.pattern_word[1] <= pwdata;
                REG_PATTERN_WORD_2: cfg_reg.pattern_word[2] <= pwdata;
                REG_PATTERN_WORD_3: cfg_reg.pattern_word[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PATTERN_LENGTH: prdata = {{(CFG_DATA_W-CFG_LEN_W){1'b0}},
                                          cfg_reg.pattern_length};
            REG_PATTERN_WORD_0: prdata = cfg_reg.pattern_word[0];
            REG_PATTERN_WORD_1: prdata = cfg_reg.pattern_word[1];
            REG_PATTERN_WORD_2: prdata = cfg_reg.pattern_word[2];
            REG_PATTERN_WORD_3: prdata = cfg_reg.pattern_word[3];
            default:            prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/cisf_cell.sv
// one cell of the match chain: remembers whether pattern bytes 0..i matched
// the text ending at the previous byte; depends on cisf_pkg

module cisf_cell
    import cisf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              clear,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic [BYTE_W-1:0] pat_byte,
    input  logic              chain_in,
    output logic              hit,
    output logic              chain_out
);

    logic partial_reg;
    logic partial_next;

    // prefix through this cell matches ending at the current byte
    assign hit = chain_in && (text_byte == pat_byte);

    always_comb begin
        partial_next = partial_reg;
        if (clear) begin
            partial_next = 1'b0;
        end else if (step) begin
            partial_next = hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= 1'b0;
        end else begin
            partial_reg <= partial_next;
        end
    end

    assign chain_out = partial_reg;

endmodule

// File: rtl/core/case_insensitive_substring_find_core.sv
// result: registered, valid in the cycle after the last item of a string is taken
// one item per cycle unless output stalls; every byte steps all cells at once
// each cell keeps one prefix-match bit, so the compare window costs no extra cycles
// reset: aresetn synchronous active low, clears config, counters, cells and m_tvalid
// depends on cisf_pkg, cisf_regs, cisf_cell

module case_insensitive_substring_find_core
    import cisf_pkg::*;
#(
    parameter int unsigned MAX_PATTERN   = 32,
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // apb configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // text input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    input  logic                  s_tuser,   // has_byte
    input  logic                  s_tlast,   // last
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] found, [POSITION_BITS:1] match_start, next 7 bits match_length, zero fill
    output logic [((POSITION_BITS+LEN_W+1+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned OUT_W = ((POSITION_BITS + LEN_W + 1 + 7) / 8) * 8;
    localparam int unsigned PAD_W = OUT_W - (POSITION_BITS + LEN_W + 1);

    cisf_cfg_t cfg;

    cisf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic                     in_xfer;
    logic                     step;
    logic                     clear;
    logic [BYTE_W-1:0]        cur_byte;
    logic [LEN_W-1:0]         len_eff;
    logic [MAX_PATTERN:0]     chain;
    logic [MAX_PATTERN-1:0]   hit_vec;
    logic                     hit;

    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic                     seen_reg, seen_next;
    logic [POSITION_BITS-1:0] offset_reg, offset_next;
    logic                     new_match;
    logic [POSITION_BITS-1:0] new_offset;

    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg, found_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LEN_W-1:0]         mlen_reg, mlen_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign step     = in_xfer && s_tuser;
    assign clear    = in_xfer && s_tlast;
    assign cur_byte = fold_case(s_tdata);

    assign len_eff = ({1'b0, cfg.pattern_length} > LEN_W'(MAX_PATTERN))
                     ? LEN_W'(MAX_PATTERN) : {1'b0, cfg.pattern_length};

    assign chain[0] = 1'b1;

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        logic [BYTE_W-1:0] pat_byte;
        if (i < PAT_BYTES) begin : g_pat
            assign pat_byte = fold_case(cfg.pattern_word[i/8][8*(i%8) +: 8]);
        end else begin : g_zero
            // pattern positions past the registers read as zero
            assign pat_byte = '0;
        end

        logic chain_in;
        if (i == 0) begin : g_head
            assign chain_in = chain[0];
        end else begin : g_body
            assign chain_in = chain[i];
        end

        cisf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (step),
            .clear     (clear),
            .text_byte (cur_byte),
            .pat_byte  (pat_byte),
            .chain_in  (chain_in),
            .hit       (hit_vec[i]),
            .chain_out (chain[i+1])
        );
    end

    // pick the cell whose index is the pattern length minus one
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (len_eff == LEN_W'(i + 1)) begin
                hit = hit | hit_vec[i];
            end
        end
    end

    assign new_match  = step && (len_eff != '0) && !seen_reg && (count_reg != '1) && hit;
    assign new_offset = count_reg - POSITION_BITS'(len_eff - LEN_W'(1));

    always_comb begin
        count_next  = count_reg;
        seen_next   = seen_reg;
        offset_next = offset_reg;
        if (new_match) begin
            seen_next   = 1'b1;
            offset_next = new_offset;
        end
        if (step && count_reg != '1) begin
            count_next = count_reg + POSITION_BITS'(1);
        end
        if (clear) begin
            count_next  = '0;
            seen_next   = 1'b0;
            offset_next = '0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        mlen_next      = mlen_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (clear) begin
            out_valid_next = 1'b1;
            if (len_eff == '0) begin
                found_next = 1'b1;
                start_next = '0;
                mlen_next  = '0;
            end else if (seen_reg || new_match) begin
                found_next = 1'b1;
                start_next = new_match ? new_offset : offset_reg;
                mlen_next  = len_eff;
            end else begin
                found_next = 1'b0;
                start_next = '0;
                mlen_next  = NO_MATCH_LEN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
        start_reg <= start_next;
        mlen_reg  <= mlen_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, mlen_reg, start_reg, found_reg};

endmodule

// File: rtl/core/cisf_checker.sv
// port-level checks for the substring search core, bound to the top level
// depends on cisf_pkg and case_insensitive_substring_find_core

module cisf_port_checks
    import cisf_pkg::*;
#(
    parameter int unsigned POSITION_BITS = 16
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [((POSITION_BITS+LEN_W+1+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned LEN_LO = POSITION_BITS + 1;

    // stalled result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no match reports zero offset and length of minus one
    a_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |->
            m_tdata[POSITION_BITS:1] == '0 &&
            m_tdata[LEN_LO +: LEN_W] == NO_MATCH_LEN)
        else $error("bad no-match encoding");

    // an empty output stage always takes input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // every new result comes from a transfer that ended a string
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !$past(m_tvalid && !m_tready) && $past(aresetn) |->
            $past(s_tvalid && s_tready && s_tlast))
        else $error("result without a final input transfer");

endmodule

bind case_insensitive_substring_find_core cisf_port_checks #(
    .POSITION_BITS (POSITION_BITS)
) u_cisf_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: verif/cisf_checker.sv
// checker for the case-insensitive substring search core: follows the apb registers,
// predicts one result per string from the accepted text transfers and compares them
// depends on cisf_pkg

module cisf_checker
    import cisf_pkg::*;
#(
    parameter int unsigned MAX_PATTERN   = 32,
    parameter int unsigned POSITION_BITS = 16,
    parameter int unsigned RES_W         = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic [CFG_DATA_W-1:0] prdata,
    input  logic                  pready,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    input  logic                  s_tuser,   // has_byte
    input  logic                  s_tlast,   // last
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [RES_W-1:0]      m_tdata,   // [0] found, [16:1] match_start, [23:17] match_length
    output int                    errors,
    output int                    pending,
    output int                    results_checked,
    output int                    matches_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                     found;
        logic [POSITION_BITS-1:0] start;
        logic [LEN_W-1:0]         match_len;
    } search_result_t;

    localparam logic [POSITION_BITS-1:0] COUNT_TOP = '1;

    logic [CFG_LEN_W-1:0]     len_reg;
    logic [CFG_DATA_W-1:0]    word_reg [PAT_WORDS];
    logic [7:0]               history [MAX_PATTERN-1];   // folded bytes, newest first
    logic [POSITION_BITS-1:0] byte_cnt;
    logic [POSITION_BITS-1:0] first_offset;
    logic                     match_latched;
    search_result_t           awaited_results [$];

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] pattern_char(input int unsigned i);
        if (i >= PAT_BYTES) begin
            return '0;
        end
        return to_lower(word_reg[i / 8][(i % 8) * 8 +: 8]);
    endfunction

    function automatic int unsigned used_length();
        return (len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(len_reg);
    endfunction

    // the arriving byte closes the pattern, older bytes fill it backwards
    function automatic bit window_hit(input logic [7:0] c, input int unsigned n);
        if (pattern_char(n - 1) != c) begin
            return 0;
        end
        for (int unsigned k = 1; k < n; k++) begin
            if (pattern_char(n - 1 - k) != history[k - 1]) begin
                return 0;
            end
        end
        return 1;
    endfunction

    function automatic void clear_string();
        history       = '{default: '0};
        byte_cnt      = '0;
        match_latched = 1'b0;
        first_offset  = '0;
    endfunction

    function automatic void scan_text_byte(input logic [7:0] b, input logic has, input logic fin);
        int unsigned    n;
        logic [7:0]     c;
        search_result_t r;
        n = used_length();
        if (has) begin
            c = to_lower(b);
            if (n > 0 && !match_latched && byte_cnt < COUNT_TOP && byte_cnt >= n - 1
                    && window_hit(c, n)) begin
                match_latched = 1'b1;
                first_offset  = byte_cnt - POSITION_BITS'(n - 1);
            end
            for (int k = MAX_PATTERN - 2; k > 0; k--) begin
                history[k] = history[k - 1];
            end
            history[0] = c;
            if (byte_cnt < COUNT_TOP) begin
                byte_cnt++;
            end
        end
        if (fin) begin
            r.found     = 1'b1;
            r.start     = '0;
            r.match_len = '0;
            if (n != 0) begin
                if (match_latched) begin
                    r.start     = first_offset;
                    r.match_len = LEN_W'(n);
                end else begin
                    r.found     = 1'b0;
                    r.match_len = NO_MATCH_LEN;
                end
            end
            awaited_results.push_back(r);
            clear_string();
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] register_value(input logic [CFG_ADDR_W-1:0] a);
        case (cisf_reg_t'(a[CFG_ADDR_W-1:3]))
            REG_PATTERN_LENGTH: return CFG_DATA_W'(len_reg);
            REG_PATTERN_WORD_0: return word_reg[0];
            REG_PATTERN_WORD_1: return word_reg[1];
            REG_PATTERN_WORD_2: return word_reg[2];
            REG_PATTERN_WORD_3: return word_reg[3];
            default:            return '0;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [CFG_DATA_W-1:0] want,
                                        input logic [CFG_DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        search_result_t want;
        if (!aresetn) begin
            len_reg  = '0;
            word_reg = '{default: '0};
            clear_string();
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer 0x%0h with no string awaiting it", m_tdata);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("found", want.found, m_tdata[0]);
                    check_field("match_start", want.start, m_tdata[POSITION_BITS:1]);
                    check_field("match_length", want.match_len,
                                m_tdata[POSITION_BITS+LEN_W:POSITION_BITS+1]);
                    results_checked++;
                    if (want.found) begin
                        matches_checked++;
                    end
                end
            end
            // a byte is compared against the registers standing before this edge
            if (s_tvalid && s_tready) begin
                scan_text_byte(s_tdata, s_tuser, s_tlast);
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (cisf_reg_t'(paddr[CFG_ADDR_W-1:3]))
                        REG_PATTERN_LENGTH: len_reg = pwdata[CFG_LEN_W-1:0];
                        REG_PATTERN_WORD_0: word_reg[0] = pwdata;
                        REG_PATTERN_WORD_1: word_reg[1] = pwdata;
                        REG_PATTERN_WORD_2: word_reg[2] = pwdata;
                        REG_PATTERN_WORD_3: word_reg[3] = pwdata;
                        default: ;
                    endcase
                end else begin
                    check_field("prdata", register_value(paddr), prdata);
                end
            end
        end
        pending = awaited_results.size();
    end

endmodule

// File: verif/tb_top.sv
// top of the substring search regression: clock, reset, apb setup, text stimulus
// and output backpressure; cisf_checker does the prediction and comparison
// depends on cisf_pkg, cisf_checker and case_insensitive_substring_find_core

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cisf_pkg::*;

    localparam int unsigned MAX_PATTERN   = 32;
    localparam int unsigned POSITION_BITS = 16;
    localparam int unsigned RES_W         = ((POSITION_BITS + LEN_W + 1 + 7) / 8) * 8;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          HOLD_CYCLES   = 400;

    // bytes around the a-z / A-Z boundaries plus two letters in both cases
    localparam logic [7:0] FOLD_EDGES [10] = '{8'h41, 8'h42, 8'h61, 8'h62, 8'h5A,
                                               8'h7A, 8'h40, 8'h5B, 8'h60, 8'h7B};

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] text_byte
    logic                  s_tuser;   // has_byte
    logic                  s_tlast;   // last
    logic                  m_tvalid;
    logic                  m_tready;
    logic [RES_W-1:0]      m_tdata;   // [0] found, [16:1] match_start, [23:17] match_length

    int errors;
    int pending;
    int results_checked;
    int matches_checked;
    int sent_items;
    int sent_strings;
    int src_idle;
    int sink_idle;
    int hold_requests;
    int cycles;

    logic [CFG_LEN_W-1:0]  pat_len;
    logic [CFG_DATA_W-1:0] pat_words [PAT_WORDS];

    case_insensitive_substring_find_core #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cisf_checker #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS),
        .RES_W         (RES_W)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .errors          (errors),
        .pending         (pending),
        .results_checked (results_checked),
        .matches_checked (matches_checked)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off whenever one is requested
    initial begin
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && served != hold_requests) begin
                served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle);
            end
        end
    end

    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 65) begin
            return FOLD_EDGES[$urandom_range(9)];
        end
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if ($urandom_range(1) == 0) begin
            return c;
        end
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] pat_byte(input int i);
        return pat_words[i / 8][(i % 8) * 8 +: 8];
    endfunction

    task automatic send_item(input logic [7:0] b, input logic has, input logic fin);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent_items++;
        if (fin) begin
            sent_strings++;
        end
    endtask

    // empty text, or now and then a trailing marker, ends the string without a byte
    task automatic send_text(input logic [7:0] text [$]);
        bit end_marker;
        end_marker = (text.size() == 0) || ($urandom_range(5) == 0);
        foreach (text[i]) begin
            if ($urandom_range(9) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(text[i], 1'b1, !end_marker && i == text.size() - 1);
        end
        if (end_marker) begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic drain_results(input int tail);
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
        repeat (tail) @(negedge aclk);
    endtask

    task automatic apb_access(input cisf_reg_t r, input logic wr, input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic program_pattern();
        drain_results(4);
        apb_access(REG_PATTERN_LENGTH, 1'b1, CFG_DATA_W'(pat_len));
        for (int w = 0; w < PAT_WORDS; w++) begin
            apb_access(cisf_reg_t'(REG_PATTERN_WORD_0 + w), 1'b1, pat_words[w]);
        end
        apb_access(REG_PATTERN_LENGTH, 1'b0, '0);
        for (int w = 0; w < PAT_WORDS; w++) begin
            apb_access(cisf_reg_t'(REG_PATTERN_WORD_0 + w), 1'b0, '0);
        end
    endtask

    task automatic random_pattern();
        case ($urandom_range(9))
            0:       pat_len = 0;
            1:       pat_len = 1;
            2:       pat_len = 32;
            3:       pat_len = 33;
            4:       pat_len = 63;
            default: pat_len = CFG_LEN_W'($urandom_range(2, 8));
        endcase
        for (int w = 0; w < PAT_WORDS; w++) begin
            if ($urandom_range(3) == 0) begin
                pat_words[w] = {$urandom, $urandom};
            end else begin
                for (int b = 0; b < 8; b++) begin
                    pat_words[w][b * 8 +: 8] = pick_char();
                end
            end
        end
        program_pattern();
    endtask

    // short noisy text, half the time with the pattern dropped in at a random spot
    task automatic send_random_string();
        logic [7:0] text [$];
        int         n;
        int         plen;
        int         at;
        plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
        n    = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(12);
        repeat (n) text.push_back(pick_char());
        if (plen != 0 && $urandom_range(1) == 1) begin
            at = $urandom_range(n);
            for (int i = 0; i < plen; i++) begin
                text.insert(at + i, flip_case(pat_byte(i)));
            end
        end
        send_text(text);
    endtask

    task automatic random_traffic(input int count);
        int stop;
        stop = sent_items + count;
        while (sent_items < stop) begin
            if ($urandom_range(19) == 0) begin
                random_pattern();
            end
            send_random_string();
        end
    endtask

    initial begin
        logic [7:0] text [$];
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        s_tlast       = 1'b0;
        src_idle      = 0;
        sink_idle     = 0;
        hold_requests = 0;
        sent_items    = 0;
        sent_strings  = 0;
        cycles        = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        src_idle  = 6;
        sink_idle = 60;

        // empty pattern matches everything at offset zero, empty strings included
        pat_len   = 0;
        pat_words = '{64'h0, 64'h0, 64'h0, '1};
        program_pattern();
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h41, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);

        // "@Az[" sits right on the fold boundaries
        pat_len   = 4;
        pat_words = '{64'h5B7A_4140, 64'h0, 64'h0, 64'h0};
        program_pattern();
        send_text('{8'h78, 8'h40, 8'h61, 8'h5A, 8'h5B});
        send_text('{8'h60, 8'h41, 8'h5A, 8'h5B});
        send_text('{8'h40, 8'h41, 8'h7A, 8'h7B});
        send_text('{8'h40, 8'h61});

        // length above the maximum is clamped; zero pattern bytes vs the cleared window
        pat_len   = 63;
        pat_words = '{64'h00FF_415A_617A_405B, '1, 64'h0, 64'h8040_2010_0804_0201};
        program_pattern();
        for (int i = 0; i < PAT_BYTES; i++) begin
            text.push_back(flip_case(pat_byte(i)));
        end
        send_text(text);

        random_traffic(330);

        drain_results(4);
        src_idle  = 60;
        sink_idle = 6;
        random_traffic(170);
        drain_results(4);
        random_traffic(170);

        drain_results(4);
        src_idle  = 0;
        sink_idle = 0;
        random_traffic(160);
        // results back up during the hold-off until the input stalls
        hold_requests++;
        repeat (60) send_item(pick_char(), 1'b1, 1'b1);
        random_traffic(170);

        drain_results(10);
        $display("search run: %0d text transfers in %0d strings, %0d results compared, %0d matched",
                 sent_items, sent_strings, results_checked, matches_checked);
        $display("covered empty and clamped patterns, fold edges, output hold-off and stalls");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
